// ===== rtl/cosine_similarity_accumulator_macros.svh =====
// assertion macros shared by the cosine similarity block
// every module that asserts has ports named i_clk and i_rst_n
`ifndef COSINE_SIMILARITY_ACCUMULATOR_MACROS_SVH
`define COSINE_SIMILARITY_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define CSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csa assertion failed");

// next-cycle implication
`define CSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csa assertion failed");

`endif

// ===== rtl/csa_pkg.sv =====
// widths, limits and shared types of the cosine similarity block
// no dependencies; used by every module of the block
package csa_pkg;

    localparam int ELEM_W      = 16;
    localparam int MAX_LEN     = 512;
    localparam int LEN_W       = $clog2(MAX_LEN);
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int NORM_W      = PROD_W - 2 + LEN_W + 1;
    localparam int DOT_W       = NORM_W + 1;
    localparam int ACC_W       = DOT_W + 1;

    localparam int SIM_W       = 16;
    localparam int SIM_FRAC    = SIM_W - 1;
    localparam int SEARCH_BITS = SIM_W;
    localparam int SB_IDX_W    = $clog2(SEARCH_BITS);
    // dot^2 is scaled by (2 * 2^frac)^2
    localparam int R_SHIFT     = 2 * SIM_FRAC + 2;
    localparam int WIDE_W      = 2 * NORM_W + 2 * (SEARCH_BITS + 1) + 2;
    localparam int S_INIT_SH   = 2 * SEARCH_BITS;
    localparam int V_INIT_SH   = SEARCH_BITS + 1;
    localparam int CNT_W       = ($clog2(NORM_W) > SB_IDX_W) ? $clog2(NORM_W) : SB_IDX_W;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = $signed(ACC_W'(MAX_LEN) << (PROD_W - 2));
    localparam logic [SIM_W:0]   SIM_FULL = (SIM_W + 1)'(1) << SIM_FRAC;
    localparam logic [SIM_W:0]   SIM_MAX  = SIM_FULL - (SIM_W + 1)'(1);

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       n1;
        logic [NORM_W-1:0]       n2;
        logic                    sat;
    } t_acc;

    typedef struct packed {
        logic [NORM_W-1:0] n1;
        logic [NORM_W-1:0] n2;
        logic [NORM_W-1:0] mag;
    } t_root_req;

endpackage

// ===== rtl/csa_mac.sv =====
// multiply-accumulate unit: one signed multiplier and one saturating adder
// shared over the dot product and both squared norms; uses csa_pkg
module csa_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [csa_pkg::ELEM_W-1:0] i_a,
    input  logic signed [csa_pkg::ELEM_W-1:0] i_b,
    input  logic                            i_clear,
    output logic                            o_busy,
    output logic                            o_done,
    output csa_pkg::t_acc                   o_acc
);

    localparam logic [1:0] STEP_AB = 2'd0;
    localparam logic [1:0] STEP_AA = 2'd1;
    localparam logic [1:0] STEP_BB = 2'd2;
    localparam logic [1:0] STEP_N2 = 2'd3;

    logic                              r_busy;
    logic                              r_done;
    logic [1:0]                        r_step;
    logic signed [csa_pkg::ELEM_W-1:0] r_a;
    logic signed [csa_pkg::ELEM_W-1:0] r_b;
    logic signed [csa_pkg::PROD_W-1:0] r_prod;
    logic signed [csa_pkg::DOT_W-1:0]  r_dot;
    logic [csa_pkg::NORM_W-1:0]        r_n1;
    logic [csa_pkg::NORM_W-1:0]        r_n2;
    logic                              r_sat;

    logic signed [csa_pkg::ELEM_W-1:0] w_x;
    logic signed [csa_pkg::ELEM_W-1:0] w_y;
    logic signed [csa_pkg::PROD_W-1:0] w_prod;
    logic signed [csa_pkg::ACC_W-1:0]  w_acc_in;
    logic signed [csa_pkg::ACC_W-1:0]  w_prod_ext;
    logic signed [csa_pkg::ACC_W-1:0]  w_sum;
    logic signed [csa_pkg::ACC_W-1:0]  w_clamp;
    logic                              w_clip;

    always_comb begin
        unique case (r_step)
            STEP_AA: begin
                w_x = r_a;
                w_y = r_a;
            end
            STEP_BB: begin
                w_x = r_b;
                w_y = r_b;
            end
            default: begin
                w_x = r_a;
                w_y = r_b;
            end
        endcase
    end

    assign w_prod = w_x * w_y;

    // the product of the previous step goes into its accumulator
    always_comb begin
        unique case (r_step)
            STEP_AA: w_acc_in = csa_pkg::ACC_W'(r_dot);
            STEP_BB: w_acc_in = $signed(csa_pkg::ACC_W'(r_n1));
            STEP_N2: w_acc_in = $signed(csa_pkg::ACC_W'(r_n2));
            default: w_acc_in = '0;
        endcase
    end

    assign w_prod_ext = csa_pkg::ACC_W'(r_prod);
    assign w_sum      = w_acc_in + w_prod_ext;

    always_comb begin
        w_clip  = 1'b0;
        w_clamp = w_sum;
        if (w_sum > csa_pkg::ACC_LIMIT) begin
            w_clip  = 1'b1;
            w_clamp = csa_pkg::ACC_LIMIT;
        end else if (w_sum < -csa_pkg::ACC_LIMIT) begin
            w_clip  = 1'b1;
            w_clamp = -csa_pkg::ACC_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_AB;
            r_dot  <= '0;
            r_n1   <= '0;
            r_n2   <= '0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_clear) begin
                r_dot <= '0;
                r_n1  <= '0;
                r_n2  <= '0;
                r_sat <= 1'b0;
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_AB;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                r_prod <= w_prod;
                if (r_step != STEP_AB) begin
                    if (w_clip) begin
                        r_sat <= 1'b1;
                    end
                end
                unique case (r_step)
                    STEP_AA: r_dot <= w_clamp[csa_pkg::DOT_W-1:0];
                    STEP_BB: r_n1  <= w_clamp[csa_pkg::NORM_W-1:0];
                    STEP_N2: begin
                        r_n2   <= w_clamp[csa_pkg::NORM_W-1:0];
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_busy    = r_busy;
    assign o_done    = r_done;
    assign o_acc.dot = r_dot;
    assign o_acc.n1  = r_n1;
    assign o_acc.n2  = r_n2;
    assign o_acc.sat = r_sat;

endmodule

// ===== rtl/csa_root.sv =====
// ratio unit: finds the largest m with (2m-1)^2 * n1 * n2 <= 2^32 * dot^2
// one shared wide adder does two shift-add products, then a bit-by-bit
// search with incremental squares; uses csa_pkg and the macro header
`include "cosine_similarity_accumulator_macros.svh"

module csa_root (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  csa_pkg::t_root_req                i_req,
    input  logic                              i_ack,
    output logic                              o_done,
    output logic [csa_pkg::SEARCH_BITS-1:0]   o_m
);

    localparam logic [3:0] R_IDLE   = 4'd0;
    localparam logic [3:0] R_MUL_NN = 4'd1;
    localparam logic [3:0] R_MUL_DD = 4'd2;
    localparam logic [3:0] R_INIT   = 4'd3;
    localparam logic [3:0] R_TRY_A  = 4'd4;
    localparam logic [3:0] R_TRY_B  = 4'd5;
    localparam logic [3:0] R_TRY_C  = 4'd6;
    localparam logic [3:0] R_TRY_D  = 4'd7;
    localparam logic [3:0] R_DONE   = 4'd8;

    localparam int W = csa_pkg::WIDE_W;

    logic [3:0]                         r_state;
    logic [csa_pkg::CNT_W-1:0]          r_cnt;
    // r_t: nn*k^2, r_v: nn*k scaled by 2^(j+2), r_s: nn*2^(2j+2) (multiplicand when multiplying)
    logic signed [W-1:0]                r_t;
    logic signed [W-1:0]                r_v;
    logic signed [W-1:0]                r_s;
    logic signed [W-1:0]                r_r;
    logic signed [W-1:0]                r_tmp;
    logic [csa_pkg::NORM_W-1:0]         r_mplier;
    logic [csa_pkg::NORM_W-1:0]         r_mag;
    logic [csa_pkg::SEARCH_BITS-1:0]    r_m;

    logic signed [W-1:0]                w_opa;
    logic signed [W-1:0]                w_opb;
    logic                               w_sub;
    logic signed [W-1:0]                w_sum;
    logic                               w_last;
    logic [csa_pkg::SB_IDX_W-1:0]       w_bit;

    always_comb begin
        w_opa = r_tmp;
        w_opb = '0;
        w_sub = 1'b0;
        unique case (r_state)
            R_MUL_NN, R_MUL_DD: begin
                w_opa = r_tmp;
                w_opb = r_mplier[0] ? r_s : '0;
            end
            R_INIT: begin
                w_opa = '0;
                w_opb = r_t <<< csa_pkg::V_INIT_SH;
                w_sub = 1'b1;
            end
            R_TRY_A: begin
                w_opa = r_t;
                w_opb = r_s;
            end
            R_TRY_B: begin
                w_opa = r_tmp;
                w_opb = r_v;
            end
            R_TRY_C: begin
                w_opa = r_r;
                w_opb = r_tmp;
                w_sub = 1'b1;
            end
            R_TRY_D: begin
                w_opa = r_v;
                w_opb = r_s <<< 1;
            end
            default: ;
        endcase
    end

    assign w_sum  = w_opa + (w_sub ? ~w_opb : w_opb) + $signed(W'(w_sub));
    assign w_last = (r_cnt == '0);
    assign w_bit  = r_cnt[csa_pkg::SB_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_s      <= $signed(W'(i_req.n1));
                        r_mplier <= i_req.n2;
                        r_mag    <= i_req.mag;
                        r_tmp    <= '0;
                        r_cnt    <= csa_pkg::CNT_W'(csa_pkg::NORM_W - 1);
                        r_state  <= R_MUL_NN;
                    end
                end
                R_MUL_NN: begin
                    r_tmp    <= w_sum;
                    r_s      <= r_s <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (w_last) begin
                        r_t      <= w_sum;
                        r_s      <= $signed(W'(r_mag));
                        r_mplier <= r_mag;
                        r_tmp    <= '0;
                        r_cnt    <= csa_pkg::CNT_W'(csa_pkg::NORM_W - 1);
                        r_state  <= R_MUL_DD;
                    end
                end
                R_MUL_DD: begin
                    r_tmp    <= w_sum;
                    r_s      <= r_s <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (w_last) begin
                        r_r     <= w_sum <<< csa_pkg::R_SHIFT;
                        r_state <= R_INIT;
                    end
                end
                R_INIT: begin
                    // start from k = -1: nn*k^2 = nn, nn*k = -nn
                    r_v     <= w_sum;
                    r_s     <= r_t <<< csa_pkg::S_INIT_SH;
                    r_m     <= '0;
                    r_cnt   <= csa_pkg::CNT_W'(csa_pkg::SEARCH_BITS - 1);
                    r_state <= R_TRY_A;
                end
                R_TRY_A: begin
                    r_tmp   <= w_sum;
                    r_state <= R_TRY_B;
                end
                R_TRY_B: begin
                    r_tmp   <= w_sum;
                    r_state <= R_TRY_C;
                end
                R_TRY_C: begin
                    if (!w_sum[W-1]) begin
                        r_t        <= r_tmp;
                        r_m[w_bit] <= 1'b1;
                        r_state    <= R_TRY_D;
                    end else begin
                        r_v   <= r_v >>> 1;
                        r_s   <= r_s >>> 2;
                        r_cnt <= r_cnt - 1'b1;
                        r_state <= w_last ? R_DONE : R_TRY_A;
                    end
                end
                R_TRY_D: begin
                    r_v   <= w_sum >>> 1;
                    r_s   <= r_s >>> 2;
                    r_cnt <= r_cnt - 1'b1;
                    r_state <= w_last ? R_DONE : R_TRY_A;
                end
                R_DONE: begin
                    if (i_ack) begin
                        r_state <= R_IDLE;
                    end
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == R_DONE);
    assign o_m    = r_m;

    // a rejected trial leaves the running square alone
    `CSA_ASSERT_NXT(a_reject_keeps_t, (r_state == R_TRY_C) && w_sum[W-1], $stable(r_t))
    // a finished result waits until it is taken
    `CSA_ASSERT_NXT(a_done_holds, (r_state == R_DONE) && !i_ack, (r_state == R_DONE) && $stable(r_m))
    // the second product always leads into the search
    `CSA_ASSERT_NXT(a_mul_to_init, (r_state == R_MUL_DD) && w_last, r_state == R_INIT)

endmodule

// ===== rtl/cosine_similarity_accumulator.sv =====
// top level of the cosine similarity block: handshake, sequencing, output register
// depends on csa_pkg, csa_mac, csa_root and the macro header
//
// Usage:
//   Input channel i_valid/o_ready carries one element pair (i_a_elem, i_b_elem)
//   per item, with i_last on the final pair of the vectors. Output channel
//   o_valid/i_ready carries one result item per vector: o_similarity (Q1.15),
//   o_zero_norm and o_overflow.
//   Each pair runs through one shared 16x16 multiplier and a saturating adder
//   in three passes; o_ready returns once the multiply-accumulate unit is
//   through with an item that has no last mark.
//   A last pair then goes to the ratio unit: two shift-add products of
//   NORM_W (40) bits each on one wide adder, then a 16-bit search that tries
//   each bit in adder steps A to C, with a step D for a bit that is kept,
//   before the result reaches the output register. The accumulators are
//   cleared as the ratio unit starts.
//   Reset clears all accumulators, the overflow flag in the multiply-accumulate unit and the output valid flag.
//   A result waits in the output register while i_ready is low; new pairs are
//   still accepted then, and a later result waits in the ratio unit until the
//   output register frees.
`include "cosine_similarity_accumulator_macros.svh"

module cosine_similarity_accumulator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [csa_pkg::ELEM_W-1:0]  i_a_elem,
    input  logic signed [csa_pkg::ELEM_W-1:0]  i_b_elem,
    input  logic                               i_last,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [csa_pkg::SIM_W-1:0]   o_similarity,
    output logic                               o_zero_norm,
    output logic                               o_overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    logic                               r_last;
    logic                               r_zero;
    logic                               r_neg;
    logic                               r_sat;
    logic                               r_out_valid;
    logic signed [csa_pkg::SIM_W-1:0]   r_sim;
    logic                               r_out_zero;
    logic                               r_out_ovf;

    logic                               w_accept;
    logic                               w_mac_busy;
    logic                               w_mac_done;
    csa_pkg::t_acc                      w_acc;
    logic                               w_handoff;
    csa_pkg::t_root_req                 w_req;
    logic                               w_root_done;
    logic [csa_pkg::SEARCH_BITS-1:0]    w_m;
    logic                               w_load;
    logic [csa_pkg::SIM_W:0]            w_cap;
    logic [csa_pkg::SIM_W:0]            w_neg_cap;
    logic signed [csa_pkg::SIM_W-1:0]   w_sim;
    logic signed [csa_pkg::DOT_W-1:0]   w_abs;

    assign o_ready   = (r_state == ST_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_handoff = (r_state == ST_MAC) && w_mac_done && r_last;
    assign w_load    = w_root_done && (!r_out_valid || i_ready);

    assign w_abs     = w_acc.dot[csa_pkg::DOT_W-1] ? -w_acc.dot : w_acc.dot;
    assign w_req.n1  = w_acc.n1;
    assign w_req.n2  = w_acc.n2;
    assign w_req.mag = w_abs[csa_pkg::NORM_W-1:0];

    csa_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_a     (i_a_elem),
        .i_b     (i_b_elem),
        .i_clear (w_handoff),
        .o_busy  (w_mac_busy),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    csa_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_handoff),
        .i_req   (w_req),
        .i_ack   (w_load),
        .o_done  (w_root_done),
        .o_m     (w_m)
    );

    // the search may run past full scale; clamp to +1.0, then to the output range
    always_comb begin
        w_cap     = ({1'b0, w_m} > csa_pkg::SIM_FULL) ? csa_pkg::SIM_FULL : {1'b0, w_m};
        w_neg_cap = -w_cap;
        if (r_zero) begin
            w_sim = '0;
        end else if (r_neg) begin
            w_sim = $signed(w_neg_cap[csa_pkg::SIM_W-1:0]);
        end else if (w_cap > csa_pkg::SIM_MAX) begin
            w_sim = $signed(csa_pkg::SIM_MAX[csa_pkg::SIM_W-1:0]);
        end else begin
            w_sim = $signed(w_cap[csa_pkg::SIM_W-1:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_MAC;
            ST_MAC:  if (w_mac_done) n_state = r_last ? ST_ROOT : ST_IDLE;
            ST_ROOT: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_last <= i_last;
            end
            if (w_handoff) begin
                r_zero <= (w_acc.n1 == '0) || (w_acc.n2 == '0);
                r_neg  <= w_acc.dot[csa_pkg::DOT_W-1];
                r_sat  <= w_acc.sat;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_sim       <= w_sim;
                r_out_zero  <= r_zero;
                r_out_ovf   <= r_sat;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_similarity = r_sim;
    assign o_zero_norm  = r_out_zero;
    assign o_overflow   = r_out_ovf;

    // an accepted item closes the input side and makes the multiply-accumulate unit busy
    `CSA_ASSERT_NXT(a_busy_after_accept, w_accept, !o_ready && w_mac_busy)
    // a result handed over always shows up on the output
    `CSA_ASSERT_NXT(a_load_shows, w_load, o_valid)
    // the multiply-accumulate unit is quiet while the ratio unit runs
    `CSA_ASSERT_IMP(a_mac_idle_in_root, r_state == ST_ROOT, !w_mac_busy && !w_mac_done)

endmodule

// ===== sim/csa_result_checker.sv =====
// result checker for the cosine similarity block: watches both channels,
// predicts each result from the accepted element pairs and compares field by field
// depends on csa_pkg for element and result widths
module csa_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pair_valid,
    input  logic                               i_pair_ready,
    input  logic signed [csa_pkg::ELEM_W-1:0]  i_a_elem,
    input  logic signed [csa_pkg::ELEM_W-1:0]  i_b_elem,
    input  logic                               i_last,
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    input  logic signed [csa_pkg::SIM_W-1:0]   i_similarity,
    input  logic                               i_zero_norm,
    input  logic                               i_overflow,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    // largest sum that MAX_LEN full-scale pairs can reach
    localparam longint SUM_LIMIT = longint'(csa_pkg::MAX_LEN) << (2 * csa_pkg::ELEM_W - 2);
    localparam int     SIM_TOP   = (1 << csa_pkg::SIM_FRAC) - 1;

    typedef struct {
        logic signed [csa_pkg::SIM_W-1:0] similarity;
        logic                             zero_norm;
        logic                             overflow;
    } sim_result_t;

    sim_result_t sim_expected_q[$];
    sim_result_t want;
    longint      dot_sum;
    longint      norm_a_sum;
    longint      norm_b_sum;
    bit          clamp_seen;
    int          fails;

    function longint add_norm(input longint sum, input longint sq);
        longint s;
        s = sum + sq;
        if (s > SUM_LIMIT) begin
            clamp_seen = 1'b1;
            s = SUM_LIMIT;
        end
        return s;
    endfunction

    task pair_accumulate(input longint a, input longint b);
        longint d;
        d = dot_sum + a * b;
        if (d > SUM_LIMIT) begin
            d = SUM_LIMIT;
            clamp_seen = 1'b1;
        end else if (d < -SUM_LIMIT) begin
            d = -SUM_LIMIT;
            clamp_seen = 1'b1;
        end
        dot_sum = d;
        norm_a_sum = add_norm(norm_a_sum, a * a);
        norm_b_sum = add_norm(norm_b_sum, b * b);
    endtask

    // magnitude is the largest m with (2m-1)^2 * n1 * n2 <= 2^32 * dot^2,
    // i.e. round to nearest with ties away from zero, done exactly
    function automatic sim_result_t similarity_of(input longint dot, input longint n1,
                                                  input longint n2, input bit clamped);
        sim_result_t r;
        logic [127:0] norm_prod;
        logic [127:0] dot_sq;
        logic [127:0] lhs;
        logic [63:0]  mag;
        logic [63:0]  ksq;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  m;
        int           s;
        r.overflow = clamped;
        if (n1 == 0 || n2 == 0) begin
            r.similarity = '0;
            r.zero_norm  = 1'b1;
            return r;
        end
        r.zero_norm = 1'b0;
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        norm_prod = {64'd0, 64'(n1)} * {64'd0, 64'(n2)};
        dot_sq = ({64'd0, mag} * {64'd0, mag}) << 32;
        lo = 0;
        hi = SIM_TOP + 1;
        while (lo < hi) begin
            m = (lo + hi + 1) >> 1;
            ksq = 64'(2 * m - 1) * 64'(2 * m - 1);
            lhs = norm_prod * {64'd0, ksq};
            if (lhs <= dot_sq)
                lo = m;
            else
                hi = m - 1;
        end
        if (dot < 0)
            s = -int'(lo);
        else
            s = (lo > SIM_TOP) ? SIM_TOP : int'(lo);
        r.similarity = s;
        return r;
    endfunction

    task note_fail(input string what, input sim_result_t exp_r);
        if (fails < 10)
            $display("%0t result mismatch (%s): expected sim=%0d zero_norm=%b overflow=%b, got sim=%0d zero_norm=%b overflow=%b",
                     $time, what, exp_r.similarity, exp_r.zero_norm, exp_r.overflow,
                     i_similarity, i_zero_norm, i_overflow);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dot_sum    = 0;
            norm_a_sum = 0;
            norm_b_sum = 0;
            clamp_seen = 1'b0;
            fails      = 0;
            sim_expected_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (sim_expected_q.size() == 0) begin
                    want.similarity = 'x;
                    want.zero_norm  = 'x;
                    want.overflow   = 'x;
                    note_fail("no result expected", want);
                end else begin
                    want = sim_expected_q.pop_front();
                    if (i_similarity !== want.similarity || i_zero_norm !== want.zero_norm
                        || i_overflow !== want.overflow)
                        note_fail("field", want);
                end
            end
            if (i_pair_valid && i_pair_ready) begin
                pair_accumulate(i_a_elem, i_b_elem);
                if (i_last) begin
                    sim_expected_q.push_back(similarity_of(dot_sum, norm_a_sum, norm_b_sum,
                                                           clamp_seen));
                    dot_sum    = 0;
                    norm_a_sum = 0;
                    norm_b_sum = 0;
                    clamp_seen = 1'b0;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= sim_expected_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// top of the cosine similarity regression: clock, reset, element pair stimulus,
// result-side stalls, watchdog and verdict
// depends on csa_pkg, cosine_similarity_accumulator and csa_result_checker
module tb_top;

    localparam int W          = csa_pkg::ELEM_W;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_SPAN  = 700;
    localparam int TAIL_WAIT  = 200;
    localparam int RAND_PAIRS = 500;

    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC } rx_mode_t;
    typedef enum int { EL_ANY, EL_EDGE, EL_SMALL, EL_ZERO } elem_style_t;
    typedef enum int { VK_RANDOM, VK_SAME, VK_NEGATED, VK_NEAR, VK_ZERO_A, VK_ZERO_B } vec_kind_t;

    logic                          i_clk    = 1'b0;
    logic                          i_rst_n  = 1'b0;
    logic                          i_valid  = 1'b0;
    logic                          o_ready;
    logic signed [W-1:0]           i_a_elem = '0;
    logic signed [W-1:0]           i_b_elem = '0;
    logic                          i_last   = 1'b0;
    logic                          o_valid;
    logic                          i_ready  = 1'b0;
    logic signed [csa_pkg::SIM_W-1:0] o_similarity;
    logic                          o_zero_norm;
    logic                          o_overflow;

    int fail_count;
    int pending;
    int hold_asked  = 0;
    int burst_left  = 0;
    int pairs_sent  = 0;
    int idle_cycles = 0;

    cosine_similarity_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_a_elem    (i_a_elem),
        .i_b_elem    (i_b_elem),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_similarity(o_similarity),
        .o_zero_norm (o_zero_norm),
        .o_overflow  (o_overflow)
    );

    csa_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (i_valid),
        .i_pair_ready (o_ready),
        .i_a_elem     (i_a_elem),
        .i_b_elem     (i_b_elem),
        .i_last       (i_last),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_similarity (o_similarity),
        .i_zero_norm  (o_zero_norm),
        .i_overflow   (o_overflow),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: random stall patterns, plus a long hold-off on request
    initial begin
        int       hold_served;
        int       hold_left;
        int       phase_left;
        rx_mode_t mode;
        hold_served = 0;
        hold_left   = 0;
        phase_left  = 0;
        mode        = RX_OPEN;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = HOLD_SPAN;
            end
            if (phase_left == 0) begin
                mode       = rx_mode_t'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= ((phase_left % 8) < 5);
                endcase
            end
        end
    end

    // nothing accepted on either channel for too long means the block hung
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // called and returns at a falling edge; sender idles between most bursts
    task automatic send_pair(input logic signed [W-1:0] a, input logic signed [W-1:0] b,
                             input logic mark);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_a_elem <= a;
        i_b_elem <= b;
        i_last   <= mark;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // sender pauses until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [W-1:0] pick_elem(input elem_style_t style);
        logic signed [W-1:0] v;
        case (style)
            EL_EDGE: begin
                case ($urandom_range(0, 6))
                    0: v = 16'sh8000;
                    1: v = 16'sh7FFF;
                    2: v = -16'sd1;
                    3: v = 16'sd1;
                    4: v = 16'sd0;
                    5: v = 16'sh4000;
                    default: v = 16'shC000;
                endcase
            end
            EL_SMALL: v = $urandom_range(0, 16) - 8;
            EL_ZERO:  v = ($urandom_range(0, 1) == 0) ? '0 : W'($urandom());
            default:  v = W'($urandom());
        endcase
        return v;
    endfunction

    task automatic send_vector(input int len, input vec_kind_t kind, input elem_style_t style);
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        int                  k;
        for (k = 0; k < len; k++) begin
            a = pick_elem(style);
            b = pick_elem(style);
            case (kind)
                VK_SAME:    b = a;
                VK_NEGATED: b = -a;
                VK_NEAR:    b = a + ($urandom_range(0, 64) - 32);
                VK_ZERO_A:  a = '0;
                VK_ZERO_B:  b = '0;
                default:    ;
            endcase
            send_pair(a, b, k == len - 1);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 4);
        else if (r < 9)
            return $urandom_range(5, 16);
        return $urandom_range(17, 64);
    endfunction

    initial begin
        int k;
        int base;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full scale, both signs
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh7FFF, 16'sh8000, 1'b1);
        send_pair(-16'sd1, 16'sd1, 1'b1);
        // zero norm on either side and both
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        // orthogonal and zero dot
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b1);
        // mixed magnitudes
        send_pair(-16'sd1, -16'sd1, 1'b0);
        send_pair(16'sh7FFF, 16'sh4000, 1'b0);
        send_pair(16'sd12345, -16'sd20000, 1'b1);
        send_pair(16'sd1, 16'sh7FFF, 1'b0);
        send_pair(16'sh8000, 16'sd1, 1'b1);
        drain();

        // long result hold-off: block fills up and stalls its input
        hold_asked++;
        for (k = 0; k < 10; k++)
            send_vector(2, VK_RANDOM, EL_ANY);
        drain();

        // more pairs than MAX_LEN: positive then negative dot clamp
        for (k = 0; k < csa_pkg::MAX_LEN + 8; k++)
            send_pair(16'sh8000, 16'sh8000, k == csa_pkg::MAX_LEN + 7);
        for (k = 0; k < csa_pkg::MAX_LEN + 18; k++)
            send_pair(16'sh7FFF, 16'sh8000, k == csa_pkg::MAX_LEN + 17);
        drain();

        base = pairs_sent;
        while (pairs_sent - base < RAND_PAIRS) begin
            send_vector(pick_len(), vec_kind_t'($urandom_range(0, 5)),
                        elem_style_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 14) == 0)
                drain();
        end
        drain();

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_mac.sv
rtl/csa_root.sv
rtl/cosine_similarity_accumulator.sv
sim/csa_result_checker.sv
sim/tb_top.sv
